@@ hdl/pbc_pkg.sv @@
// shared constants and types for the permutation bruhat compare unit
`default_nettype none

package pbc_pkg;

    // packing of one permutation field
    localparam int ENTRY_BITS    = 3;
    localparam int FIELD_BITS    = 24;
    localparam int FIELD_ENTRIES = FIELD_BITS / ENTRY_BITS;

    // thresholds 1 .. 2**ENTRY_BITS-1 cover every entry value
    localparam int NUM_THRESH    = (1 << ENTRY_BITS) - 1;

    // stream payload widths
    localparam int S_TDATA_W     = 2 * FIELD_BITS;
    localparam int M_TDATA_W     = 8;

    // lane stage status handed to the merge stage
    typedef struct packed {
        logic valid;
        logic equal;
    } lane_stage_t;

endpackage

`default_nettype wire

@@ hdl/pbc_lane.sv @@
// one prefix lane: dominance check of the first LANE_IDX+1 entries
`default_nettype none

module pbc_lane #(
    parameter int PERM_SIZE = 8,
    parameter int LANE_IDX  = 0
) (
    input  wire logic [PERM_SIZE-1:0][pbc_pkg::ENTRY_BITS-1:0] first_ent,
    input  wire logic [PERM_SIZE-1:0][pbc_pkg::ENTRY_BITS-1:0] second_ent,
    output logic                                               lane_ok
);

    localparam int EW    = pbc_pkg::ENTRY_BITS;
    localparam int PLEN  = LANE_IDX + 1;
    localparam int CNT_W = $clog2(PLEN + 1);

    logic [PLEN-1:0]  ge_first;
    logic [PLEN-1:0]  ge_second;
    logic [CNT_W-1:0] cnt_first;
    logic [CNT_W-1:0] cnt_second;

    // sorted prefixes dominate iff, for every threshold, the first prefix
    // holds no more entries at or above it than the second one
    always_comb begin
        lane_ok    = 1'b1;
        ge_first   = '0;
        ge_second  = '0;
        cnt_first  = '0;
        cnt_second = '0;
        for (int t = 1; t <= pbc_pkg::NUM_THRESH; t++) begin
            for (int k = 0; k < PLEN; k++) begin
                ge_first[k]  = (first_ent[k]  >= EW'(t));
                ge_second[k] = (second_ent[k] >= EW'(t));
            end
            cnt_first  = CNT_W'($countones(ge_first));
            cnt_second = CNT_W'($countones(ge_second));
            if (cnt_first > cnt_second) begin
                lane_ok = 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

@@ hdl/pbc_merge.sv @@
// merge stage: combines lane results and holds the output item
`default_nettype none

module pbc_merge #(
    parameter int NUM_LANES = 8
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic [NUM_LANES-1:0]            lane_ok,
    input  wire pbc_pkg::lane_stage_t            lane_stage,
    output logic                                 merge_ready,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [pbc_pkg::M_TDATA_W-1:0]        m_tdata
);

    logic m_valid_reg;
    logic m_valid_next;
    logic below_reg;
    logic below_next;

    // output register frees up when empty or taken
    assign merge_ready = !m_valid_reg || m_tready;

    // all lanes dominate and the permutations differ
    always_comb begin
        m_valid_next = m_valid_reg;
        below_next   = below_reg;
        if (merge_ready) begin
            m_valid_next = lane_stage.valid;
            below_next   = (&lane_ok) && !lane_stage.equal;
        end
    end

    // control register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // payload register
    always_ff @(posedge aclk) begin
        below_reg <= below_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(pbc_pkg::M_TDATA_W-1){1'b0}}, below_reg};

endmodule

`default_nettype wire

@@ hdl/permutation_bruhat_compare_unit.sv @@
// top level of the permutation bruhat compare unit
//
//  channel | dir | handshake         | payload (lowest bit up)
//  --------+-----+-------------------+----------------------------------------
//  s_      | in  | s_tvalid/s_tready | s_tdata: first_perm[23:0], second_perm[47:24]
//  m_      | out | m_tvalid/m_tready | m_tdata: strictly_below[0], zero fill [7:1]
//
//  one item per cycle while the m_ side is not stalled; an accepted item passes the lane
//  stage register and then the output register before m_tvalid shows it
//  stage one: PERM_SIZE prefix lanes, each counting entries per threshold
//  stage two: merge of the lane flags into the output register
//  aresetn (synchronous, active low) empties both stages
//  a stalled m_ side holds the output; the lane stage keeps accepting until full

`default_nettype none

module permutation_bruhat_compare_unit #(
    parameter int PERM_SIZE = 8
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [pbc_pkg::S_TDATA_W-1:0]     s_tdata,  // first_perm, second_perm
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [pbc_pkg::M_TDATA_W-1:0]          m_tdata   // strictly_below, zero fill
);

    localparam int EW = pbc_pkg::ENTRY_BITS;
    localparam int FB = pbc_pkg::FIELD_BITS;

    logic [PERM_SIZE-1:0][EW-1:0] first_ent;
    logic [PERM_SIZE-1:0][EW-1:0] second_ent;
    logic [PERM_SIZE-1:0]         lane_ok;
    logic [PERM_SIZE-1:0]         lane_ok_reg;
    logic [PERM_SIZE-1:0]         lane_ok_next;
    logic                         s1_valid_reg;
    logic                         s1_valid_next;
    logic                         s1_equal_reg;
    logic                         s1_equal_next;
    logic                         entries_equal;
    logic                         merge_ready;
    pbc_pkg::lane_stage_t         lane_stage;

    // unpack entries; those past the field read as zero
    for (genvar k = 0; k < PERM_SIZE; k++) begin : g_unpack
        if (k < pbc_pkg::FIELD_ENTRIES) begin : g_in_field
            assign first_ent[k]  = s_tdata[k*EW +: EW];
            assign second_ent[k] = s_tdata[FB + k*EW +: EW];
        end else begin : g_past_field
            assign first_ent[k]  = '0;
            assign second_ent[k] = '0;
        end
    end

    // one lane per prefix length
    for (genvar i = 0; i < PERM_SIZE; i++) begin : g_lane
        pbc_lane #(
            .PERM_SIZE (PERM_SIZE),
            .LANE_IDX  (i)
        ) u_lane (
            .first_ent  (first_ent),
            .second_ent (second_ent),
            .lane_ok    (lane_ok[i])
        );
    end

    // equality over the used entries only
    assign entries_equal = (first_ent == second_ent);

    // lane stage accepts when empty or when the merge stage takes its item
    assign s_tready = !s1_valid_reg || merge_ready;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        s1_equal_next = s1_equal_reg;
        lane_ok_next  = lane_ok_reg;
        if (s_tready) begin
            s1_valid_next = s_tvalid;
            s1_equal_next = entries_equal;
            lane_ok_next  = lane_ok;
        end
    end

    // control register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        s1_equal_reg <= s1_equal_next;
        lane_ok_reg  <= lane_ok_next;
    end

    assign lane_stage.valid = s1_valid_reg;
    assign lane_stage.equal = s1_equal_reg;

    // merge of the lane flags
    pbc_merge #(
        .NUM_LANES (PERM_SIZE)
    ) u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .lane_ok     (lane_ok_reg),
        .lane_stage  (lane_stage),
        .merge_ready (merge_ready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

`ifndef SYNTH
    // an accepted item reaches the lane stage
    a_accept_fills_lane: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> s1_valid_reg)
        else $error("accepted item missing from lane stage");

    // a lane stage item moves on into the output register
    a_lane_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && merge_ready) |=> m_tvalid)
        else $error("lane stage item lost before output");

    // a blocked lane stage keeps its flags
    a_lane_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !merge_ready) |=> (s1_valid_reg && $stable(lane_ok_reg)))
        else $error("lane stage changed while blocked");

    // equal permutations never report strictly below
    a_equal_not_below: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && merge_ready && s1_equal_reg) |=> !m_tdata[0])
        else $error("equal permutations reported as strictly below");
`endif

endmodule

`default_nettype wire
